// File: hdl/skd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skd_pkg: shared types and helpers for the sorted key dictionary
// Operation and status codes, controller states, cell control and key folding.
// ----------------------------------------------------------------------------
package skd_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int KEY_BITS   = 64;
    localparam int KIND_BITS  = 2;
    localparam int STAT_BITS  = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_SEARCH = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_SPARE  = 2'd3
    } t_kind;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EXISTS    = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } t_state;

    // control broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rem_en;
    } t_cell_ctrl;

    // lower-case ascii letters, zero every byte after the first zero byte
    function automatic logic [KEY_BITS-1:0] norm_key(input logic [KEY_BITS-1:0] k);
        logic [KEY_BITS-1:0] r;
        logic                ended;
        logic [7:0]          b;
        r     = '0;
        ended = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            b = k[i*8 +: 8];
            if (ended || (b == 8'h00)) begin
                ended = 1'b1;
                b     = 8'h00;
            end else if ((b >= 8'h41) && (b <= 8'h5A)) begin
                b = b + 8'h20;
            end
            r[i*8 +: 8] = b;
        end
        return r;
    endfunction

endpackage

// File: hdl/skd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skd_cell: one slot of the sorted table
// Holds a folded key and its value, compares against the broadcast key and
// shifts toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module skd_cell #(
    parameter int VALUE_BITS = skd_pkg::VALUE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  skd_pkg::t_cell_ctrl           i_ctrl,
    input  logic                          i_valid,
    input  logic [skd_pkg::KEY_BITS-1:0]  i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    input  logic                          i_flag,
    input  logic                          i_prev_lt,
    input  logic [skd_pkg::KEY_BITS-1:0]  i_left_key,
    input  logic [VALUE_BITS-1:0]         i_left_value,
    input  logic                          i_left_flag,
    input  logic [skd_pkg::KEY_BITS-1:0]  i_right_key,
    input  logic [VALUE_BITS-1:0]         i_right_value,
    input  logic                          i_right_flag,
    output logic [skd_pkg::KEY_BITS-1:0]  o_key,
    output logic [VALUE_BITS-1:0]         o_value,
    output logic                          o_flag,
    output logic                          o_lt,
    output logic                          o_eq
);

    logic [skd_pkg::KEY_BITS-1:0] r_key;
    logic [VALUE_BITS-1:0]        r_value;
    logic                         r_flag;
    logic                         r_lt;
    logic                         r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctrl.cmp_en) begin
            r_lt <= i_valid && (r_key < i_key);
            r_eq <= i_valid && (r_key == i_key);
        end
    end

    // cells at or past the insert/remove point take a neighbor's entry, or the new one at the insert point
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en && !r_lt) begin
            if (i_prev_lt) begin
                r_key   <= i_key;
                r_value <= i_value;
                r_flag  <= i_flag;
            end else begin
                r_key   <= i_left_key;
                r_value <= i_left_value;
                r_flag  <= i_left_flag;
            end
        end else if (i_ctrl.rem_en && !r_lt) begin
            r_key   <= i_right_key;
            r_value <= i_right_value;
            r_flag  <= i_right_flag;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_flag  = r_flag;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

// File: hdl/sorted_key_dictionary.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_dictionary: case-insensitive sorted key/value table
// Row of cells kept in key order; search, insert and remove one at a time.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one operation per transfer: tuser holds the kind (search,
//   insert, remove; the unused code searches), tdata the key, value and
//   value-present flag. m_axis returns one result per operation: tuser holds
//   the status, tdata the position, found value, its flag and entry count.
//   Each operation passes through accept, a compare state in which every
//   cell checks its key against the folded request key, and an execute state
//   that encodes the position and shifts the cells by one slot at once.
//   The result appears in the cycle after execute; a new transfer is taken
//   only once the block is back in idle, after the result is registered.
//   The result sits in an output register, so the next request is accepted
//   while it waits; a stalled receiver holds the block in execute.
//   Reset empties the table (entry count zero) and holds s_axis_tready low;
//   cell contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_key_dictionary #(
    parameter int CAPACITY   = skd_pkg::CAPACITY,
    parameter int VALUE_BITS = skd_pkg::VALUE_BITS,
    localparam int CW        = $clog2(CAPACITY + 1),
    localparam int IN_W      = ((skd_pkg::KEY_BITS + VALUE_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_W     = ((2 * CW + VALUE_BITS + 1 + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // key, value, value_present
    input  logic [IN_W-1:0]               s_axis_tdata,
    // kind
    input  logic [skd_pkg::KIND_BITS-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // position, found_value, found_has_value, entry_count
    output logic [OUT_W-1:0]              m_axis_tdata,
    // status
    output logic [skd_pkg::STAT_BITS-1:0] m_axis_tuser
);

    localparam int KB = skd_pkg::KEY_BITS;

    skd_pkg::t_state      r_state, n_state;
    skd_pkg::t_kind       r_kind;
    logic [KB-1:0]         r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_flag;
    logic [CW-1:0]         r_count, n_count;

    logic                  r_out_valid;
    skd_pkg::t_status      r_status, n_status;
    logic [CW-1:0]         r_pos;
    logic [VALUE_BITS-1:0] r_fval, n_fval;
    logic                  r_fhas, n_fhas;
    logic [CW-1:0]         r_ocount;

    skd_pkg::t_cell_ctrl   ctrl;
    logic                  commit;
    logic                  in_xfer;

    logic [KB-1:0]         c_key   [CAPACITY];
    logic [VALUE_BITS-1:0] c_value [CAPACITY];
    logic                  c_flag  [CAPACITY];
    logic [CAPACITY-1:0]   c_lt;
    logic [CAPACITY-1:0]   c_eq;

    logic [CW-1:0]         pos_c;
    logic [VALUE_BITS-1:0] hit_value;
    logic                  hit_flag;
    logic                  hit;

    // no transfer is taken while reset is held
    assign s_axis_tready = i_rst_n && (r_state == skd_pkg::ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign commit        = (r_state == skd_pkg::ST_EXEC) && (!r_out_valid || m_axis_tready);

    // ---------------- controller ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        ctrl.cmp_en = 1'b0;
        ctrl.ins_en = 1'b0;
        ctrl.rem_en = 1'b0;
        case (r_state)
            skd_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = skd_pkg::ST_CMP;
                end
            end
            skd_pkg::ST_CMP: begin
                ctrl.cmp_en = 1'b1;
                n_state     = skd_pkg::ST_EXEC;
            end
            skd_pkg::ST_EXEC: begin
                if (commit) begin
                    n_state = skd_pkg::ST_IDLE;
                    ctrl.ins_en = (r_kind == skd_pkg::KIND_INSERT) && !hit &&
                                  (r_count != CW'(CAPACITY));
                    ctrl.rem_en = (r_kind == skd_pkg::KIND_REMOVE) && hit;
                end
            end
            default: n_state = skd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind  <= skd_pkg::t_kind'(s_axis_tuser);
            r_key   <= skd_pkg::norm_key(s_axis_tdata[KB-1:0]);
            r_value <= s_axis_tdata[KB+VALUE_BITS] ? s_axis_tdata[KB +: VALUE_BITS] : '0;
            r_flag  <= s_axis_tdata[KB+VALUE_BITS];
        end
    end

    // ---------------- cell row ----------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KB-1:0]         left_key,   right_key;
        logic [VALUE_BITS-1:0] left_value, right_value;
        logic                  left_flag,  right_flag;
        logic                  prev_lt;

        if (g == 0) begin : g_first
            assign left_key   = r_key;
            assign left_value = r_value;
            assign left_flag  = r_flag;
            assign prev_lt    = 1'b1;
        end else begin : g_mid
            assign left_key   = c_key[g-1];
            assign left_value = c_value[g-1];
            assign left_flag  = c_flag[g-1];
            assign prev_lt    = c_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_key   = c_key[g];
            assign right_value = c_value[g];
            assign right_flag  = c_flag[g];
        end else begin : g_inner
            assign right_key   = c_key[g+1];
            assign right_value = c_value[g+1];
            assign right_flag  = c_flag[g+1];
        end

        skd_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (ctrl),
            .i_valid       (CW'(g) < r_count),
            .i_key         (r_key),
            .i_value       (r_value),
            .i_flag        (r_flag),
            .i_prev_lt     (prev_lt),
            .i_left_key    (left_key),
            .i_left_value  (left_value),
            .i_left_flag   (left_flag),
            .i_right_key   (right_key),
            .i_right_value (right_value),
            .i_right_flag  (right_flag),
            .o_key         (c_key[g]),
            .o_value       (c_value[g]),
            .o_flag        (c_flag[g]),
            .o_lt          (c_lt[g]),
            .o_eq          (c_eq[g])
        );
    end

    // lt flags form a thermometer; the position is where it drops to zero
    always_comb begin
        pos_c     = c_lt[CAPACITY-1] ? CW'(CAPACITY) : '0;
        hit_value = '0;
        hit_flag  = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (((i == 0) || c_lt[(i == 0) ? 0 : i-1]) && !c_lt[i]) begin
                pos_c = pos_c | CW'(i);
            end
            if (c_eq[i]) begin
                hit_value = hit_value | c_value[i];
                hit_flag  = hit_flag | c_flag[i];
            end
        end
    end

    assign hit = |c_eq;

    // ---------------- result ----------------
    always_comb begin
        n_count  = r_count;
        n_status = skd_pkg::STAT_OK;
        n_fval   = '0;
        n_fhas   = 1'b0;
        case (r_kind)
            skd_pkg::KIND_INSERT: begin
                if (hit) begin
                    n_status = skd_pkg::STAT_EXISTS;
                end else if (r_count == CW'(CAPACITY)) begin
                    n_status = skd_pkg::STAT_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            skd_pkg::KIND_REMOVE: begin
                if (!hit) begin
                    n_status = skd_pkg::STAT_NOT_FOUND;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                if (!hit) begin
                    n_status = skd_pkg::STAT_NOT_FOUND;
                end else begin
                    n_fval = hit_value;
                    n_fhas = hit_flag;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_status <= n_status;
            r_pos    <= pos_c;
            r_fval   <= n_fval;
            r_fhas   <= n_fhas;
            r_ocount <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = OUT_W'({r_ocount, r_fhas, r_fval, r_pos});

endmodule

// File: tb/sv/dictionary_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dictionary_checker: result predictor and scoreboard for the sorted key table
// Watches both stream channels, keeps its own sorted table with case-folded
// key compares, queues the expected result of every accepted operation and
// compares each returned result against the oldest one, field by field.
// ----------------------------------------------------------------------------
module dictionary_checker #(
    parameter int IN_W  = 104,
    parameter int OUT_W = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    // key, value, value_present
    input  logic [IN_W-1:0]               i_s_tdata,
    // kind
    input  logic [skd_pkg::KIND_BITS-1:0] i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    // position, found_value, found_has_value, entry_count
    input  logic [OUT_W-1:0]              i_m_tdata,
    // status
    input  logic [skd_pkg::STAT_BITS-1:0] i_m_tuser,
    output int                            o_fail_count,
    output int                            o_pending
);

    import skd_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef struct packed {
        t_status               status;
        logic [CW-1:0]         position;
        logic [VALUE_BITS-1:0] found_value;
        logic                  found_has_value;
        logic [CW-1:0]         entry_count;
    } dict_result_t;

    logic [KEY_BITS-1:0]   tbl_key [CAPACITY];
    logic [VALUE_BITS-1:0] tbl_val [CAPACITY];
    logic                  tbl_has [CAPACITY];
    int                    tbl_count = 0;
    int                    fail_total = 0;
    dict_result_t          pending_results [$];
    dict_result_t          want;
    dict_result_t          pred;

    // letters to lower case, everything from the first zero byte on reads as zero
    function automatic logic [KEY_BITS-1:0] fold_key(input logic [KEY_BITS-1:0] raw);
        logic [KEY_BITS-1:0] folded;
        logic                live;
        logic [7:0]          c;
        folded = '0;
        live   = 1'b1;
        for (int n = 0; n < 8; n++) begin
            c = raw[KEY_BITS-1-8*n -: 8];
            if (c == 8'h00)
                live = 1'b0;
            if (live) begin
                if (c >= 8'h41 && c <= 8'h5A)
                    c = c | 8'h20;
                folded[KEY_BITS-1-8*n -: 8] = c;
            end
        end
        return folded;
    endfunction

    task automatic apply_op(input t_kind kind, input logic [KEY_BITS-1:0] key,
                            input logic [VALUE_BITS-1:0] val, input logic has,
                            output dict_result_t r);
        logic [KEY_BITS-1:0] probe;
        int                  slot;
        logic                hit;
        r     = '0;
        probe = fold_key(key);
        slot  = 0;
        hit   = 1'b0;
        // lower bound over the live entries
        for (int i = 0; i < tbl_count; i++) begin
            if (fold_key(tbl_key[i]) < probe)
                slot++;
            else if (fold_key(tbl_key[i]) == probe)
                hit = 1'b1;
        end
        r.status = STAT_OK;
        case (kind)
            KIND_INSERT: begin
                if (hit) begin
                    r.status = STAT_EXISTS;
                end else if (tbl_count >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    for (int i = tbl_count; i > slot; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_val[i] = tbl_val[i-1];
                        tbl_has[i] = tbl_has[i-1];
                    end
                    tbl_key[slot] = key;
                    tbl_val[slot] = has ? val : '0;
                    tbl_has[slot] = has;
                    tbl_count++;
                end
            end
            KIND_REMOVE: begin
                if (!hit) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    for (int i = slot; i < tbl_count - 1; i++) begin
                        tbl_key[i] = tbl_key[i+1];
                        tbl_val[i] = tbl_val[i+1];
                        tbl_has[i] = tbl_has[i+1];
                    end
                    tbl_count--;
                end
            end
            default: begin
                // search, and the spare kind behaves the same
                if (!hit) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    r.found_value     = tbl_val[slot];
                    r.found_has_value = tbl_has[slot];
                end
            end
        endcase
        r.position    = CW'(slot);
        r.entry_count = CW'(tbl_count);
    endtask

    task automatic check_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tbl_count = 0;
            pending_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: result transfer with none expected, actual 0x%0h/0x%0h",
                             $time, i_m_tuser, i_m_tdata);
                    fail_total++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, i_m_tuser);
                    check_field("position", want.position, i_m_tdata[CW-1:0]);
                    check_field("found_value", want.found_value,
                                i_m_tdata[CW +: VALUE_BITS]);
                    check_field("found_has_value", want.found_has_value,
                                i_m_tdata[CW+VALUE_BITS]);
                    check_field("entry_count", want.entry_count,
                                i_m_tdata[CW+VALUE_BITS+1 +: CW]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_op(t_kind'(i_s_tuser), i_s_tdata[KEY_BITS-1:0],
                         i_s_tdata[KEY_BITS +: VALUE_BITS], i_s_tdata[KEY_BITS+VALUE_BITS],
                         pred);
                pending_results.push_back(pred);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_results.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the sorted key dictionary
// Directed operations on folding, duplicates, empty and junk-padded keys, then
// phases of random traffic that fill the table to capacity, mix and drain it,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import skd_pkg::*;

    localparam int CW             = $clog2(CAPACITY + 1);
    localparam int IN_W           = ((KEY_BITS + VALUE_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_W          = ((2 * CW + VALUE_BITS + 1 + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int POOL_SIZE      = 96;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int PHASE_LEN      = 200;

    typedef enum int {
        PH_FILL,
        PH_MIXED,
        PH_DRAIN,
        PH_NOISE
    } t_phase;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic [KIND_BITS-1:0] s_tuser  = '0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [OUT_W-1:0]     m_tdata;
    wire  [STAT_BITS-1:0] m_tuser;

    int                   sent_cnt     = 0;
    int                   recv_cnt     = 0;
    int                   quiet_cycles = 0;
    int                   fail_count;
    int                   pending;
    int                   ops_by_kind [4] = '{0, 0, 0, 0};
    int                   item_idx     = 0;
    int                   phase_cnt    = 0;
    bit                   hold_done    = 1'b0;
    logic [KEY_BITS-1:0]  key_pool [POOL_SIZE];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    sorted_key_dictionary DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    dictionary_checker #(
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // transfer counters and watchdog
    always @(posedge i_clk) begin
        if (s_tvalid && s_tready)
            sent_cnt <= sent_cnt + 1;
        if (m_tvalid && m_tready)
            recv_cnt <= recv_cnt + 1;
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random back-pressure, one long hold-off, one quiet stretch
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && !hold_done && recv_cnt >= 300) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_tready <= (recv_cnt >= 700 && recv_cnt < 1000) || ($urandom_range(99) >= 6);
            end
        end
    end

    function automatic logic [KEY_BITS-1:0] text_key(input string s);
        logic [KEY_BITS-1:0] k;
        k = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            k[KEY_BITS-1-8*i -: 8] = s[i];
        return k;
    endfunction

    // pool key with random letter case and, sometimes, junk after the terminator
    function automatic logic [KEY_BITS-1:0] pool_variant(input int idx);
        logic [KEY_BITS-1:0] k;
        logic [7:0]          c;
        logic                ended;
        logic                junk;
        k     = key_pool[idx];
        ended = 1'b0;
        junk  = ($urandom_range(3) == 0);
        for (int b = 7; b >= 0; b--) begin
            c = k[b*8 +: 8];
            if (ended) begin
                if (junk)
                    c = 8'($urandom_range(255));
            end else if (c == 8'h00) begin
                ended = 1'b1;
            end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
                if ($urandom_range(1))
                    c = c ^ 8'h20;
            end
            k[b*8 +: 8] = c;
        end
        return k;
    endfunction

    function automatic t_kind choose_kind(input t_phase ph);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return KIND_SPARE;
        case (ph)
            PH_FILL:  return (r < 80) ? KIND_INSERT : (r < 90) ? KIND_SEARCH : KIND_REMOVE;
            PH_MIXED: return (r < 40) ? KIND_INSERT : (r < 70) ? KIND_SEARCH : KIND_REMOVE;
            PH_DRAIN: return (r < 15) ? KIND_INSERT : (r < 35) ? KIND_SEARCH : KIND_REMOVE;
            default:  return (r < 35) ? KIND_INSERT : (r < 70) ? KIND_SEARCH : KIND_REMOVE;
        endcase
    endfunction

    // call right after a rising edge; returns at the edge of the transfer
    task automatic push_op(input t_kind kind, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] val, input logic has);
        int gap;
        if (!(item_idx >= 700 && item_idx < 1000) && $urandom_range(99) < 6) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({has, val, key});
        s_tuser  <= kind;
        ops_by_kind[kind]++;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (recv_cnt < sent_cnt) @(posedge i_clk);
    endtask

    initial begin
        t_phase              ph;
        t_kind               kind;
        logic [KEY_BITS-1:0] key;
        logic [KEY_BITS-1:0] k;
        logic [7:0]          c;
        int                  len;

        // key pool: mostly letters of both cases, some arbitrary nonzero bytes
        for (int p = 0; p < POOL_SIZE; p++) begin
            k   = '0;
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(9) < 7)
                    c = 8'h61 + 8'($urandom_range(25)) - ($urandom_range(1) ? 8'h20 : 8'h00);
                else
                    c = 8'($urandom_range(1, 255));
                k[KEY_BITS-1-8*i -: 8] = c;
            end
            key_pool[p] = k;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        push_op(KIND_SEARCH, text_key("abc"), 32'h0, 1'b0);
        push_op(KIND_REMOVE, text_key("abc"), 32'h0, 1'b0);
        push_op(KIND_INSERT, text_key("Mango"), 32'hFFFF_FFFF, 1'b1);
        push_op(KIND_INSERT, text_key("apple"), 32'h1234_5678, 1'b0);
        push_op(KIND_INSERT, text_key("MANGO"), 32'h0000_0000, 1'b1);
        push_op(KIND_SEARCH, text_key("mAnGo"), 32'h0, 1'b0);
        push_op(KIND_SEARCH, text_key("APPLE"), 32'h0, 1'b1);
        push_op(KIND_INSERT, '0, 32'h0000_0000, 1'b1);
        push_op(KIND_INSERT, '1, 32'h5A5A_A5A5, 1'b1);
        // "ki" followed by junk after the terminator
        push_op(KIND_INSERT, 64'h6B69_00A5_FF12_3456, 32'h0000_0001, 1'b1);
        push_op(KIND_SEARCH, text_key("KI"), 32'h0, 1'b0);
        push_op(KIND_INSERT, text_key("ki"), 32'h0, 1'b1);
        push_op(KIND_INSERT, text_key("A@Z["), 32'h8000_0000, 1'b1);
        push_op(KIND_SEARCH, text_key("a@z["), 32'h0, 1'b0);
        // bytes just outside the letter ranges do not fold
        push_op(KIND_SEARCH, 64'h6160_7A7B_0000_0000, 32'h0, 1'b0);
        push_op(KIND_SPARE, text_key("mango"), 32'h0, 1'b0);
        push_op(KIND_SPARE, text_key("zzz"), 32'h0, 1'b0);
        push_op(KIND_REMOVE, text_key("Apple"), 32'h0, 1'b0);
        push_op(KIND_SEARCH, text_key("apple"), 32'h0, 1'b0);
        push_op(KIND_REMOVE, '1, 32'h0, 1'b0);
        push_op(KIND_REMOVE, '0, 32'h0, 1'b0);
        push_op(KIND_REMOVE, text_key("kI"), 32'h0, 1'b0);
        wait_drained();

        // random part in phases, sender pauses for a full drain between them
        for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++) begin
            if (item_idx % PHASE_LEN == 0) begin
                if (item_idx > 0)
                    wait_drained();
                phase_cnt++;
            end
            ph   = t_phase'((item_idx / PHASE_LEN) % 4);
            kind = choose_kind(ph);
            if ($urandom_range(99) < ((ph == PH_NOISE) ? 40 : 8))
                key = {$urandom, $urandom};
            else
                key = pool_variant($urandom_range(POOL_SIZE - 1));
            push_op(kind, key, $urandom, 1'($urandom_range(1)));
        end
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("%0d operations sent (%0d search, %0d insert, %0d remove, %0d spare kind), %0d results checked",
                 sent_cnt, ops_by_kind[KIND_SEARCH], ops_by_kind[KIND_INSERT],
                 ops_by_kind[KIND_REMOVE], ops_by_kind[KIND_SPARE], recv_cnt);
        $display("%0d random phases filling the table to capacity and draining it, with folded-case and junk-padded keys",
                 phase_cnt);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
